FILE: rtl/core/scac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scac_pkg;

  // widths fixed by the item formats
  localparam int ANGLE_W          = 16;
  localparam int ENCODER_BITS     = 12;
  localparam int TABLE_INDEX_BITS = 7;
  localparam int DUTY_W           = 16;
  localparam int CFG_ADDR_W       = 2;
  localparam int CFG_DATA_W       = 16;

  // defaults for the top level parameters
  localparam int CORR_TABLE_DEPTH_DEF = 128;
  localparam int SINE_TABLE_BITS_DEF  = 10;

  // angle constants in 1/65536 turn
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;
  localparam logic [ANGLE_W-1:0] PHASE_THIRD  = 16'd21845;

  // pi/2 in Q30
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic {
    OP_WRITE     = 1'b0,
    OP_COMMUTATE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_POLE_PAIRS   = 2'd0,
    CFG_MOUNT_OFFSET = 2'd1,
    CFG_ELEC_ZERO    = 2'd2,
    CFG_MAX_DUTY     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    opcode_t                       opcode;
    logic [TABLE_INDEX_BITS-1:0]   table_index;
    logic signed [15:0]            correction_value;
    logic [ENCODER_BITS-1:0]       encoder_angle;
    logic signed [15:0]            torque_command;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_phase_u;
    logic [DUTY_W-1:0] duty_phase_v;
    logic [DUTY_W-1:0] duty_phase_w;
  } out_item_t;

  // quarter-wave sine entry in Q1.15, odd Taylor series to x^11 in Q30
  function automatic logic [14:0] quarter_sine(input int unsigned q, input int unsigned stb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] r;
    x  = (64'(q) * PI_HALF_Q30) >> (stb - 2);
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    r  = (x * t) >> 30;
    r  = (r + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scac_phase_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module scac_phase_lane #(
  parameter int SINE_TABLE_BITS = scac_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           adv,
  input  wire logic [scac_pkg::ANGLE_W-1:0]   angle,
  input  wire logic signed [15:0]             torque,
  input  wire logic [scac_pkg::DUTY_W-1:0]    duty_full,
  output logic [scac_pkg::DUTY_W-1:0]         duty
);

  localparam int QTR   = 2 ** (SINE_TABLE_BITS - 2);
  localparam int Q_W   = SINE_TABLE_BITS - 1;

  // quarter-wave sine rom, quarter point included
  logic [14:0] rom [QTR+1];
  for (genvar g = 0; g <= QTR; g++) begin : g_rom
    assign rom[g] = scac_pkg::quarter_sine(g, SINE_TABLE_BITS);
  end

  // table index, quadrant fold
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [Q_W-1:0]             q_nxt;
  assign idx   = angle[15 -: SINE_TABLE_BITS];
  assign q_nxt = idx[SINE_TABLE_BITS-2] ?
                 (Q_W'(QTR) - Q_W'(idx[SINE_TABLE_BITS-3:0])) :
                 Q_W'(idx[SINE_TABLE_BITS-3:0]);

  logic [Q_W-1:0]       q_r;
  logic                 neg_a_r;
  logic signed [15:0]   trq_a_r;
  logic [14:0]          mag_r;
  logic                 neg_b_r;
  logic signed [15:0]   trq_b_r;
  logic signed [31:0]   tprod_r;
  logic signed [47:0]   sprod_r;

  logic signed [15:0]   sin_s;
  logic signed [31:0]   tprod_nxt;
  logic signed [47:0]   sprod_nxt;

  // signed sine, torque product, scale by half duty
  assign sin_s     = neg_b_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign tprod_nxt = trq_b_r * sin_s;
  assign sprod_nxt = 48'(tprod_r) * 48'($signed({1'b0, duty_full[15:1]}));

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r     <= q_nxt;
      neg_a_r <= idx[SINE_TABLE_BITS-1];
      trq_a_r <= torque;
      mag_r   <= rom[q_r];
      neg_b_r <= neg_a_r;
      trq_b_r <= trq_a_r;
      tprod_r <= tprod_nxt;
      sprod_r <= sprod_nxt;
    end
  end

  // add midpoint and rounding half, clamp at zero, saturate at max duty
  logic signed [47:0] vr;
  logic [17:0]        d;
  assign vr   = sprod_r + $signed({3'b0, duty_full[15:1], 1'b1, 29'b0});
  assign d    = vr[47] ? 18'd0 : vr[47:30];
  assign duty = (d > {2'b0, duty_full}) ? duty_full : d[15:0];

endmodule

`default_nettype wire

FILE: rtl/core/sine_commutation_with_angle_correction_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   payload                 handshake
// in_       in    scac_pkg::in_item_t     in_valid / in_ready
// out_      out   scac_pkg::out_item_t    out_valid / out_ready
// cfg_      in    index 2 b, data 16 b    cfg_we, no wait
//
// one item per cycle while the output is not stalled; a commutate item gives
// its duties after the registers for correction memory read, interpolation
// multiply, field sum, quadrant fold, sine rom, two duty multiplies and output register.
// a table write takes effect at transfer.
// synchronous reset sets pole pairs to 7 and clears the other config registers,
// the table valid bits and the pipeline valids; the table needs no clearing pass.
// a stalled output freezes the whole pipeline; in_ready = !out_valid || out_ready.
module sine_commutation_with_angle_correction_top #(
  parameter int CORR_TABLE_DEPTH = scac_pkg::CORR_TABLE_DEPTH_DEF,
  parameter int SINE_TABLE_BITS  = scac_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire scac_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output scac_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [scac_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [scac_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int TIDX_DEPTH = 2 ** scac_pkg::TABLE_INDEX_BITS;
  localparam int BIN_W      = $clog2(CORR_TABLE_DEPTH);
  localparam int WR_DEPTH   = (CORR_TABLE_DEPTH < TIDX_DEPTH) ? CORR_TABLE_DEPTH : TIDX_DEPTH;
  localparam int WR_AW      = $clog2(WR_DEPTH);
  localparam int POS_W      = 16 + BIN_W + 1;
  localparam int LAT        = 7;

  // configuration registers
  logic [4:0]  pp_r;
  logic [15:0] moff_r;
  logic [15:0] ez_r;
  logic [15:0] maxd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r   <= 5'd7;
      moff_r <= '0;
      ez_r   <= '0;
      maxd_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        scac_pkg::CFG_POLE_PAIRS:   pp_r   <= cfg_wdata[4:0];
        scac_pkg::CFG_MOUNT_OFFSET: moff_r <= cfg_wdata;
        scac_pkg::CFG_ELEC_ZERO:    ez_r   <= cfg_wdata;
        scac_pkg::CFG_MAX_DUTY:     maxd_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance and transfer
  logic adv;
  logic in_xfer;
  logic cmd_xfer;
  logic tbl_we;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign in_xfer  = in_valid && adv;
  assign cmd_xfer = in_xfer && (in_data.opcode == scac_pkg::OP_COMMUTATE);

  // mechanical angle and correction bins
  logic [15:0]      mech;
  logic [POS_W-1:0] pos;
  logic [BIN_W-1:0] bin0;
  logic [BIN_W-1:0] bin1;
  logic [WR_AW-1:0] addr0;
  logic [WR_AW-1:0] addr1;
  logic             rd0_ok;
  logic             rd1_ok;
  logic [WR_AW-1:0] waddr;

  assign mech   = (16'(in_data.encoder_angle) << (16 - scac_pkg::ENCODER_BITS)) + moff_r;
  assign pos    = POS_W'(mech) * POS_W'(CORR_TABLE_DEPTH);
  assign bin0   = pos[16 +: BIN_W];
  assign bin1   = (bin0 == BIN_W'(CORR_TABLE_DEPTH - 1)) ? '0 : bin0 + BIN_W'(1);
  assign addr0  = bin0[WR_AW-1:0];
  assign addr1  = bin1[WR_AW-1:0];
  assign rd0_ok = 32'(bin0) < 32'(WR_DEPTH);
  assign rd1_ok = 32'(bin1) < 32'(WR_DEPTH);
  assign waddr  = in_data.table_index[WR_AW-1:0];
  assign tbl_we = in_xfer && (in_data.opcode == scac_pkg::OP_WRITE)
                  && (32'(in_data.table_index) < 32'(WR_DEPTH));

  // correction memory: one write port, two registered read ports
  logic signed [15:0] mem [WR_DEPTH];
  logic [WR_DEPTH-1:0] ent_vld_r;
  logic signed [15:0] rd0_r;
  logic signed [15:0] rd1_r;
  logic               hit0_r;
  logic               hit1_r;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem[waddr] <= in_data.correction_value;
    end
    if (adv) begin
      rd0_r <= mem[addr0];
      rd1_r <= mem[addr1];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (tbl_we) begin
      ent_vld_r[waddr] <= 1'b1;
    end
  end

  // stage 1 payload
  logic [15:0]        mech_r;
  logic [15:0]        frac_r;
  logic signed [15:0] trq1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit0_r <= rd0_ok && ent_vld_r[addr0];
      hit1_r <= rd1_ok && ent_vld_r[addr1];
      mech_r <= mech;
      frac_r <= pos[15:0];
      trq1_r <= in_data.torque_command;
    end
  end

  // stage 2: electrical angle, interpolation product
  logic signed [15:0] c0;
  logic signed [15:0] c1;
  logic signed [16:0] diff;
  logic signed [33:0] dprod_nxt;
  logic [20:0]        elec_full;
  logic [15:0]        elec_nxt;

  assign c0        = hit0_r ? rd0_r : '0;
  assign c1        = hit1_r ? rd1_r : '0;
  assign diff      = {c1[15], c1} - {c0[15], c0};
  assign dprod_nxt = diff * $signed({1'b0, frac_r});
  assign elec_full = 21'(mech_r) * 21'(pp_r);
  assign elec_nxt  = elec_full[15:0] - ez_r;

  logic [15:0]        elec_r;
  logic signed [33:0] dprod_r;
  logic signed [15:0] c0_r;
  logic signed [15:0] trq2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      elec_r  <= elec_nxt;
      dprod_r <= dprod_nxt;
      c0_r    <= c0;
      trq2_r  <= trq1_r;
    end
  end

  // stage 3: rounded interpolation, field angle with quarter-turn advance
  logic signed [34:0] rnd;
  logic [15:0]        field_nxt;
  assign rnd       = 35'(dprod_r) + 35'sd32768;
  assign field_nxt = elec_r + $unsigned(c0_r) + rnd[31:16] + scac_pkg::QUARTER_TURN;

  logic [15:0]        field_r;
  logic signed [15:0] trq3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      field_r <= field_nxt;
      trq3_r  <= trq2_r;
    end
  end

  // three phase lanes
  logic [15:0] ang_u;
  logic [15:0] ang_v;
  logic [15:0] ang_w;
  logic [15:0] duty_u;
  logic [15:0] duty_v;
  logic [15:0] duty_w;
  assign ang_u = field_r;
  assign ang_v = field_r - scac_pkg::PHASE_THIRD;
  assign ang_w = field_r + scac_pkg::PHASE_THIRD;

  scac_phase_lane #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_lane_u (
    .clk(clk), .adv(adv), .angle(ang_u), .torque(trq3_r), .duty_full(maxd_r), .duty(duty_u)
  );
  scac_phase_lane #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_lane_v (
    .clk(clk), .adv(adv), .angle(ang_v), .torque(trq3_r), .duty_full(maxd_r), .duty(duty_v)
  );
  scac_phase_lane #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_lane_w (
    .clk(clk), .adv(adv), .angle(ang_w), .torque(trq3_r), .duty_full(maxd_r), .duty(duty_w)
  );

  // valid chain and output register
  logic [LAT-1:0]      vld_r;
  logic                out_valid_r;
  scac_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], cmd_xfer};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.duty_phase_u <= duty_u;
      out_data_r.duty_phase_v <= duty_v;
      out_data_r.duty_phase_w <= duty_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/scac_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module scac_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire scac_pkg::in_item_t              in_data,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire scac_pkg::out_item_t             out_data
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // stalled result keeps its duties
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // input side takes a transfer exactly when the pipeline can advance
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // a waiting input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input offer changed while waiting");

endmodule

bind sine_commutation_with_angle_correction_top scac_checker u_scac_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

`default_nettype wire
